@@ sv/sbfh_pkg.sv @@
// Package for the segment/box first-hit pipeline: side codes and fixed-point constants.
package sbfh_pkg;

	// Default signed coordinate width, whole numbers (Q24.0) in the default build
	localparam int COORD_WIDTH_DEF = 24;

	// Slope carries this many fraction bits
	localparam int SLOPE_SHIFT = 16;

	// Which test produced the hit
	typedef enum logic [2:0] {
		SIDE_NONE   = 3'd0,
		SIDE_INSIDE = 3'd1,
		SIDE_LEFT   = 3'd2,
		SIDE_RIGHT  = 3'd3,
		SIDE_TOP    = 3'd4,
		SIDE_BOTTOM = 3'd5
	} side_t;

endpackage

@@ sv/sbfh_div_pipe.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband bus.
module sbfh_div_pipe #(
	parameter int NUM_W  = 41,
	parameter int DEN_W  = 25,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [NUM_W-1:0]  out_quo,
	output logic [SIDE_W-1:0] out_side
);

	// Per-stage registers: numerator bits shift out at the top, quotient bits in at the bottom
	logic [NUM_W-1:0]  nq_s   [1:NUM_W];
	logic [DEN_W-1:0]  rem_s  [1:NUM_W];
	logic [DEN_W-1:0]  den_s  [1:NUM_W];
	logic [SIDE_W-1:0] side_s [1:NUM_W];
	logic [NUM_W:1]    vld_s;

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic [NUM_W-1:0]  src_nq;
		logic [DEN_W-1:0]  src_rem;
		logic [DEN_W-1:0]  src_den;
		logic [SIDE_W-1:0] src_side;
		logic              src_vld;
		logic [DEN_W:0]    trial;
		logic              fit;

		// Select the stage source: ports for the first stage, previous stage otherwise
		if (k == 0) begin : g_src
			assign src_nq   = in_num;
			assign src_rem  = '0;
			assign src_den  = in_den;
			assign src_side = in_side;
			assign src_vld  = in_vld;
		end else begin : g_src
			assign src_nq   = nq_s[k];
			assign src_rem  = rem_s[k];
			assign src_den  = den_s[k];
			assign src_side = side_s[k];
			assign src_vld  = vld_s[k];
		end

		// Bring down the next numerator bit and try one subtract
		assign trial = {src_rem, src_nq[NUM_W-1]};
		assign fit   = trial >= {1'b0, src_den};

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= src_vld;
			end
		end

		// Advance the payload
		always_ff @(posedge clk) begin
			nq_s[k+1]   <= {src_nq[NUM_W-2:0], fit};
			rem_s[k+1]  <= fit ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];
			den_s[k+1]  <= src_den;
			side_s[k+1] <= src_side;
		end
	end

	assign out_vld  = vld_s[NUM_W];
	assign out_quo  = nq_s[NUM_W];
	assign out_side = side_s[NUM_W];

endmodule

@@ sv/segment_box_first_hit_top.sv @@
// Top level of the segment/box first-hit pipeline.
// Every start that is taken yields one result strobe on done.
// Throughput: one beat per cycle; busy stays low, so start may be high in every cycle.
// The latency is set by two bit-serial divider pipelines (slope and top/bottom crossing).
// The receiver cannot stall: every result is shown on done for exactly one cycle.
// Reset (arst_n low) clears all valid bits at once; beats in flight are dropped.
module segment_box_first_hit_top #(
	parameter int COORD_WIDTH = sbfh_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] box_center_x,
	input  logic signed [COORD_WIDTH-1:0] box_center_y,
	input  logic        [COORD_WIDTH-2:0] box_half_w,
	input  logic        [COORD_WIDTH-2:0] box_half_h,
	input  logic                          target_is_box,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] hit_x,
	output logic signed [COORD_WIDTH-1:0] hit_y,
	output logic        [2:0]             hit_side,
	output logic                          clipped
);

	localparam int W   = COORD_WIDTH;
	localparam int SH  = sbfh_pkg::SLOPE_SHIFT;
	localparam int EW  = W + 1;          // edges, deltas
	localparam int MW  = W + 1;          // magnitudes
	localparam int QW  = MW + SH;        // slope magnitude, divider widths
	localparam int HL  = (QW + 1) / 2;   // low slice of slope for the split multiply
	localparam int HH  = QW - HL;
	localparam int PW  = QW + MW;        // product magnitude
	localparam int YW  = PW - SH + 2;    // signed line value at an edge
	localparam int NW  = W + 2;          // signed edge minus start y
	localparam int XW  = QW + 2;         // signed x at a top or bottom crossing
	localparam int SB1 = 2 * W + 4 * EW + 2 * MW + 5;
	localparam int SB2 = 3 * W + 5;
	localparam int LAT = 2 * QW + 6;

	localparam longint CMAX = (longint'(1) << (W - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;
	localparam logic signed [YW-1:0] Y_HI = YW'(CMAX);
	localparam logic signed [YW-1:0] Y_LO = YW'(CMIN);
	localparam logic signed [EW-1:0] E_HI = EW'(CMAX);
	localparam logic signed [EW-1:0] E_LO = EW'(CMIN);
	localparam logic signed [XW-1:0] X_HI = XW'(CMAX);
	localparam logic signed [XW-1:0] X_LO = XW'(CMIN);

	logic accept;

	// The pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------- Stage 1: edges and deltas ----------------
	logic                 vld_s1;
	logic                 box_s1;
	logic signed [W-1:0]  sx_s1, sy_s1;
	logic signed [EW-1:0] lx_s1, rx_s1, by_s1, ty_s1, dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Capture the beat and form the box edges at full width
	always_ff @(posedge clk) begin
		box_s1 <= target_is_box;
		sx_s1  <= start_x;
		sy_s1  <= start_y;
		lx_s1  <= EW'(box_center_x) - EW'(box_half_w);
		rx_s1  <= EW'(box_center_x) + EW'(box_half_w);
		by_s1  <= EW'(box_center_y) - EW'(box_half_h);
		ty_s1  <= EW'(box_center_y) + EW'(box_half_h);
		dx_s1  <= EW'(end_x) - EW'(start_x);
		dy_s1  <= EW'(end_y) - EW'(start_y);
	end

	// Inside test, signs and magnitudes for the slope divider
	logic                 inside_c, run_c, sneg_c;
	logic [MW-1:0]        dxm_c, dym_c, dlm_c, drm_c;
	logic signed [EW:0]   dl_c, dr_c;
	logic                 dln_c, drn_c;

	always_comb begin
		inside_c = box_s1 && (lx_s1 < sx_s1) && (sx_s1 < rx_s1)
		        && (by_s1 < sy_s1) && (sy_s1 < ty_s1);
		run_c    = box_s1 && !inside_c && (dx_s1 != '0);
		sneg_c   = dx_s1[EW-1] ^ dy_s1[EW-1];
		dxm_c    = MW'(dx_s1[EW-1] ? -dx_s1 : dx_s1);
		dym_c    = MW'(dy_s1[EW-1] ? -dy_s1 : dy_s1);
		dl_c     = (EW+1)'(lx_s1) - (EW+1)'(sx_s1);
		dr_c     = (EW+1)'(rx_s1) - (EW+1)'(sx_s1);
		dln_c    = dl_c[EW];
		drn_c    = dr_c[EW];
		dlm_c    = MW'(dln_c ? -dl_c : dl_c);
		drm_c    = MW'(drn_c ? -dr_c : dr_c);
	end

	// ---------------- Slope divider ----------------
	logic            d1_vld;
	logic [QW-1:0]   d1_quo;
	logic [SB1-1:0]  d1_side;

	sbfh_div_pipe #(
		.NUM_W  (QW),
		.DEN_W  (MW),
		.SIDE_W (SB1)
	) u_div_slope (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_num   ({dym_c, {SH{1'b0}}}),
		.in_den   (dxm_c),
		.in_side  ({sx_s1, sy_s1, lx_s1, rx_s1, by_s1, ty_s1, inside_c, run_c, sneg_c,
		            dlm_c, dln_c, drm_c, drn_c}),
		.out_vld  (d1_vld),
		.out_quo  (d1_quo),
		.out_side (d1_side)
	);

	logic signed [W-1:0]  sx_d1, sy_d1;
	logic signed [EW-1:0] lx_d1, rx_d1, by_d1, ty_d1;
	logic                 inside_d1, run_d1, sneg_d1, dln_d1, drn_d1;
	logic [MW-1:0]        dlm_d1, drm_d1;

	assign {sx_d1, sy_d1, lx_d1, rx_d1, by_d1, ty_d1, inside_d1, run_d1, sneg_d1,
	        dlm_d1, dln_d1, drm_d1, drn_d1} = d1_side;

	// ---------------- Stage 2: split partial products ----------------
	logic                 vld_s2, vld_s3, vld_s4, vld_s5;
	logic [HL+MW-1:0]     pll_s2, prl_s2;
	logic [HH+MW-1:0]     plh_s2, prh_s2;
	logic [QW-1:0]        q_s2, q_s3, q_s4, q_s5;
	logic signed [W-1:0]  sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4, sx_s5;
	logic signed [EW-1:0] lx_s2, rx_s2, by_s2, ty_s2;
	logic signed [EW-1:0] lx_s3, rx_s3, by_s3, ty_s3;
	logic signed [EW-1:0] lx_s4, rx_s4, by_s4, ty_s4;
	logic                 inside_s2, run_s2, sneg_s2, yln_s2, yrn_s2;
	logic                 inside_s3, run_s3, sneg_s3, yln_s3, yrn_s3;
	logic                 inside_s4, run_s4, sneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= d1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Multiply each slope slice by the distance to the left and right edges
	always_ff @(posedge clk) begin
		pll_s2    <= (HL+MW)'(d1_quo[HL-1:0]) * (HL+MW)'(dlm_d1);
		plh_s2    <= (HH+MW)'(d1_quo[QW-1:HL]) * (HH+MW)'(dlm_d1);
		prl_s2    <= (HL+MW)'(d1_quo[HL-1:0]) * (HL+MW)'(drm_d1);
		prh_s2    <= (HH+MW)'(d1_quo[QW-1:HL]) * (HH+MW)'(drm_d1);
		q_s2      <= d1_quo;
		sx_s2     <= sx_d1;
		sy_s2     <= sy_d1;
		lx_s2     <= lx_d1;
		rx_s2     <= rx_d1;
		by_s2     <= by_d1;
		ty_s2     <= ty_d1;
		inside_s2 <= inside_d1;
		run_s2    <= run_d1;
		sneg_s2   <= sneg_d1;
		yln_s2    <= sneg_d1 ^ dln_d1;
		yrn_s2    <= sneg_d1 ^ drn_d1;
	end

	// ---------------- Stage 3: combine partial products ----------------
	logic [PW-1:0] pml_s3, pmr_s3;

	always_ff @(posedge clk) begin
		pml_s3    <= (PW'(plh_s2) << HL) + PW'(pll_s2);
		pmr_s3    <= (PW'(prh_s2) << HL) + PW'(prl_s2);
		q_s3      <= q_s2;
		sx_s3     <= sx_s2;
		sy_s3     <= sy_s2;
		lx_s3     <= lx_s2;
		rx_s3     <= rx_s2;
		by_s3     <= by_s2;
		ty_s3     <= ty_s2;
		inside_s3 <= inside_s2;
		run_s3    <= run_s2;
		sneg_s3   <= sneg_s2;
		yln_s3    <= yln_s2;
		yrn_s3    <= yrn_s2;
	end

	// ---------------- Stage 4: line values at the left and right edges ----------------
	logic signed [YW-1:0] yl_s4, yr_s4;
	logic [PW-SH-1:0]     tl_c, tr_c;

	// Truncate toward zero on the magnitude, then restore the sign
	assign tl_c = pml_s3[PW-1:SH];
	assign tr_c = pmr_s3[PW-1:SH];

	always_ff @(posedge clk) begin
		yl_s4     <= YW'(sy_s3) + (yln_s3 ? -YW'(tl_c) : YW'(tl_c));
		yr_s4     <= YW'(sy_s3) + (yrn_s3 ? -YW'(tr_c) : YW'(tr_c));
		q_s4      <= q_s3;
		sx_s4     <= sx_s3;
		sy_s4     <= sy_s3;
		lx_s4     <= lx_s3;
		rx_s4     <= rx_s3;
		by_s4     <= by_s3;
		ty_s4     <= ty_s3;
		inside_s4 <= inside_s3;
		run_s4    <= run_s3;
		sneg_s4   <= sneg_s3;
	end

	// ---------------- Stage 5: pick the side ----------------
	sbfh_pkg::side_t      side_c;
	logic signed [W-1:0]  hx_c, hy_c;
	logic                 clip_c;
	logic signed [NW-1:0] numy_c;
	logic signed [YW-1:0] ty_w, by_w, hy_w;
	logic signed [EW-1:0] hx_e;
	logic                 lft_c, rgt_c, top_c, bot_c, snz_c;

	always_comb begin
		ty_w   = YW'(ty_s4);
		by_w   = YW'(by_s4);
		snz_c  = q_s4 != '0;
		lft_c  = (by_w < yl_s4) && (yl_s4 < ty_w) && (EW'(sx_s4) < lx_s4);
		rgt_c  = (by_w < yr_s4) && (yr_s4 < ty_w) && (rx_s4 < EW'(sx_s4));
		top_c  = snz_c && (EW'(sy_s4) > ty_s4)
		      && (((yl_s4 > ty_w) && (yr_s4 < ty_w)) || ((yr_s4 > ty_w) && (yl_s4 < ty_w)));
		bot_c  = snz_c && (EW'(sy_s4) < by_s4)
		      && (((yl_s4 > by_w) && (yr_s4 < by_w)) || ((yr_s4 > by_w) && (yl_s4 < by_w)));
		side_c = sbfh_pkg::SIDE_NONE;
		hx_e   = '0;
		hy_w   = '0;
		numy_c = '0;
		if (inside_s4) begin
			side_c = sbfh_pkg::SIDE_INSIDE;
			hx_e   = EW'(sx_s4);
			hy_w   = YW'(sy_s4);
		end else if (run_s4 && lft_c) begin
			side_c = sbfh_pkg::SIDE_LEFT;
			hx_e   = lx_s4;
			hy_w   = yl_s4;
		end else if (run_s4 && rgt_c) begin
			side_c = sbfh_pkg::SIDE_RIGHT;
			hx_e   = rx_s4;
			hy_w   = yr_s4;
		end else if (run_s4 && top_c) begin
			side_c = sbfh_pkg::SIDE_TOP;
			hy_w   = ty_w;
			numy_c = NW'(ty_s4) - NW'(sy_s4);
		end else if (run_s4 && bot_c) begin
			side_c = sbfh_pkg::SIDE_BOTTOM;
			hy_w   = by_w;
			numy_c = NW'(by_s4) - NW'(sy_s4);
		end
		// Saturate the known coordinates
		clip_c = 1'b0;
		if (hy_w > Y_HI) begin
			hy_c   = W'(CMAX);
			clip_c = 1'b1;
		end else if (hy_w < Y_LO) begin
			hy_c   = W'(CMIN);
			clip_c = 1'b1;
		end else begin
			hy_c = hy_w[W-1:0];
		end
		if (hx_e > E_HI) begin
			hx_c   = W'(CMAX);
			clip_c = 1'b1;
		end else if (hx_e < E_LO) begin
			hx_c   = W'(CMIN);
			clip_c = 1'b1;
		end else begin
			hx_c = hx_e[W-1:0];
		end
	end

	sbfh_pkg::side_t      side_s5;
	logic signed [W-1:0]  hx_s5, hy_s5;
	logic                 clip_s5, sneg_s5;
	logic signed [NW-1:0] numy_s5;

	always_ff @(posedge clk) begin
		side_s5 <= side_c;
		hx_s5   <= hx_c;
		hy_s5   <= hy_c;
		clip_s5 <= clip_c;
		numy_s5 <= numy_c;
		sx_s5   <= sx_s4;
		sneg_s5 <= sneg_s4;
		q_s5    <= q_s4;
	end

	// Magnitude of the edge offset for the crossing divider
	logic          nneg_c;
	logic [MW-1:0] nmag_c;

	assign nneg_c = numy_s5[NW-1];
	assign nmag_c = MW'(nneg_c ? -numy_s5 : numy_s5);

	// ---------------- Crossing divider ----------------
	logic           d2_vld;
	logic [QW-1:0]  d2_quo;
	logic [SB2-1:0] d2_side;

	sbfh_div_pipe #(
		.NUM_W  (QW),
		.DEN_W  (QW),
		.SIDE_W (SB2)
	) u_div_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_num   ({nmag_c, {SH{1'b0}}}),
		.in_den   (q_s5),
		.in_side  ({side_s5, hx_s5, hy_s5, clip_s5, sx_s5, nneg_c ^ sneg_s5}),
		.out_vld  (d2_vld),
		.out_quo  (d2_quo),
		.out_side (d2_side)
	);

	logic [2:0]          side_d2;
	logic signed [W-1:0] hx_d2, hy_d2, sx_d2;
	logic                clip_d2, qneg_d2;

	assign {side_d2, hx_d2, hy_d2, clip_d2, sx_d2, qneg_d2} = d2_side;

	// ---------------- Stage 6: crossing x and result register ----------------
	logic signed [XW-1:0] xw_c;
	logic signed [W-1:0]  fx_c;
	logic                 fclip_c;

	always_comb begin
		xw_c    = XW'(sx_d2) + (qneg_d2 ? -XW'(d2_quo) : XW'(d2_quo));
		fx_c    = hx_d2;
		fclip_c = clip_d2;
		if (side_d2 == sbfh_pkg::SIDE_TOP || side_d2 == sbfh_pkg::SIDE_BOTTOM) begin
			if (xw_c > X_HI) begin
				fx_c    = W'(CMAX);
				fclip_c = 1'b1;
			end else if (xw_c < X_LO) begin
				fx_c    = W'(CMIN);
				fclip_c = 1'b1;
			end else begin
				fx_c = xw_c[W-1:0];
			end
		end
	end

	logic                vld_s6;
	logic signed [W-1:0] hx_s6, hy_s6;
	logic [2:0]          side_s6;
	logic                clip_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		hx_s6   <= fx_c;
		hy_s6   <= hy_d2;
		side_s6 <= side_d2;
		clip_s6 <= fclip_c;
	end

	assign done     = vld_s6;
	assign hit_x    = hx_s6;
	assign hit_y    = hy_s6;
	assign hit_side = side_s6;
	assign clipped  = clip_s6;

	// ---------------- Assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result beat missing at fixed latency");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (hit_side == sbfh_pkg::SIDE_NONE) |-> (hit_x == '0) && (hit_y == '0) && !clipped)
		else $error("miss beat carries a nonzero point");

	a_clip_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> hit_side != sbfh_pkg::SIDE_NONE)
		else $error("clipped set without a hit");

	a_inside_noclip: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && (side_s5 == sbfh_pkg::SIDE_INSIDE) |-> !clip_s5)
		else $error("inside hit was saturated");

endmodule

@@ tb/segment_box_first_hit_top_test.sv @@
// Self-checking testbench for the segment/box first-hit pipeline.
module segment_box_first_hit_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 24;
	localparam int LATENCY = 2 * CW + 40;
	localparam int N_RANDOM = 1650;
	localparam longint SLOPE_ONE = 64'sd1 << sbfh_pkg::SLOPE_SHIFT;

	typedef struct {
		logic signed [CW-1:0] sx, sy, ex, ey, cx, cy;
		logic [CW-2:0] hw, hh;
		logic isbox;
	} shot_t;

	typedef struct {
		logic signed [CW-1:0] hx, hy;
		sbfh_pkg::side_t side;
		logic clip;
	} hit_t;

	typedef struct {
		shot_t s;
		bit known;
		hit_t h;
	} row_t;

	logic clk, arst_n, start, busy, target_is_box, done, clipped;
	logic signed [CW-1:0] start_x, start_y, end_x, end_y, box_center_x, box_center_y;
	logic [CW-2:0] box_half_w, box_half_h;
	logic signed [CW-1:0] hit_x, hit_y;
	logic [2:0] hit_side;

	hit_t pending_hits[$];
	row_t rows[$];
	int errors = 0;

	segment_box_first_hit_top #(.COORD_WIDTH(CW)) dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// Saturating product to +-2^62
	function automatic longint mul_sat(longint a, longint b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		if (p > (128'sd1 <<< 62)) return 64'sd1 <<< 62;
		if (p < -(128'sd1 <<< 62)) return -(64'sd1 <<< 62);
		return longint'(p);
	endfunction

	function automatic longint sat_coord(longint v, ref logic clip);
		longint hi, lo;
		hi = (64'sd1 <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin clip = 1; return hi; end
		if (v < lo) begin clip = 1; return lo; end
		return v;
	endfunction

	function automatic bit straddles(longint a, longint b, longint lvl);
		return (a > lvl && b < lvl) || (b > lvl && a < lvl);
	endfunction

	// Predict the first hit of a shot line on a box
	function automatic hit_t first_hit(shot_t s);
		hit_t h;
		longint sx, sy, lx, rx, by, ty, dx, dy, slope, yl, yr, hx, hy;
		logic clip;
		sx = s.sx; sy = s.sy;
		hx = 0; hy = 0; clip = 0;
		h.side = sbfh_pkg::SIDE_NONE;
		if (s.isbox) begin
			lx = longint'(s.cx) - longint'(s.hw);
			rx = longint'(s.cx) + longint'(s.hw);
			by = longint'(s.cy) - longint'(s.hh);
			ty = longint'(s.cy) + longint'(s.hh);
			dx = longint'(s.ex) - sx;
			dy = longint'(s.ey) - sy;
			if (lx < sx && sx < rx && by < sy && sy < ty) begin
				hx = sx; hy = sy; h.side = sbfh_pkg::SIDE_INSIDE;
			end else if (dx != 0) begin
				slope = (dy * SLOPE_ONE) / dx;
				yl = sy + mul_sat(slope, lx - sx) / SLOPE_ONE;
				yr = sy + mul_sat(slope, rx - sx) / SLOPE_ONE;
				if (by < yl && yl < ty && sx < lx) begin
					hx = lx; hy = yl; h.side = sbfh_pkg::SIDE_LEFT;
				end else if (by < yr && yr < ty && rx < sx) begin
					hx = rx; hy = yr; h.side = sbfh_pkg::SIDE_RIGHT;
				end else if (slope != 0 && sy > ty && straddles(yl, yr, ty)) begin
					hx = sx + ((ty - sy) * SLOPE_ONE) / slope; hy = ty;
					h.side = sbfh_pkg::SIDE_TOP;
				end else if (slope != 0 && sy < by && straddles(yl, yr, by)) begin
					hx = sx + ((by - sy) * SLOPE_ONE) / slope; hy = by;
					h.side = sbfh_pkg::SIDE_BOTTOM;
				end
			end
			if (h.side != sbfh_pkg::SIDE_NONE) begin
				hx = sat_coord(hx, clip);
				hy = sat_coord(hy, clip);
			end
		end
		h.hx = hx[CW-1:0];
		h.hy = hy[CW-1:0];
		h.clip = clip;
		return h;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return CW'($urandom);
			1: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			default: return CW'($signed($urandom_range(0, 20000)) - 10000);
		endcase
	endfunction

	function automatic logic [CW-2:0] rand_half();
		case ($urandom_range(0, 4))
			0: return (CW-1)'($urandom);
			1: return {(CW-1){1'b1}};
			default: return (CW-1)'($urandom_range(0, 5000));
		endcase
	endfunction

	// Mostly shots aimed near the box, some fully random
	function automatic shot_t rand_shot();
		shot_t s;
		s.cx = rand_coord(); s.cy = rand_coord();
		s.hw = rand_half(); s.hh = rand_half();
		s.sx = rand_coord(); s.sy = rand_coord();
		if ($urandom_range(0, 3) != 0) begin
			s.ex = s.cx + CW'($signed($urandom_range(0, 2000)) - 1000);
			s.ey = s.cy + CW'($signed($urandom_range(0, 2000)) - 1000);
		end else begin
			s.ex = rand_coord(); s.ey = rand_coord();
		end
		if ($urandom_range(0, 15) == 0) s.ex = s.sx;
		s.isbox = $urandom_range(0, 9) != 0;
		return s;
	endfunction

	function automatic shot_t mk(int sx, int sy, int ex, int ey, int cx, int cy,
			int hw, int hh, bit isbox);
		shot_t s;
		s.sx = CW'(sx); s.sy = CW'(sy); s.ex = CW'(ex); s.ey = CW'(ey);
		s.cx = CW'(cx); s.cy = CW'(cy);
		s.hw = (CW-1)'(hw); s.hh = (CW-1)'(hh); s.isbox = isbox;
		return s;
	endfunction

	function automatic hit_t hv(int x, int y, sbfh_pkg::side_t sd, bit c);
		hit_t h;
		h.hx = CW'(x); h.hy = CW'(y); h.side = sd; h.clip = c;
		return h;
	endfunction

	task automatic add_row(shot_t s, bit known, hit_t h);
		row_t r;
		r.s = s; r.known = known; r.h = h;
		rows.insert(rows.size(), r);
	endtask

	// Build the directed table
	task automatic build_table();
		hit_t z;
		int mx, mn;
		z = hv(0, 0, sbfh_pkg::SIDE_NONE, 0);
		mx = (1 << (CW - 1)) - 1;
		mn = -(1 << (CW - 1));
		add_row(mk(0, 0, 256, 0, 0, 0, 512, 512, 0), 1, z);
		add_row(mk(10, 20, 50, 50, 0, 0, 512, 512, 1), 1,
			hv(10, 20, sbfh_pkg::SIDE_INSIDE, 0));
		add_row(mk(-2000, 0, 0, 0, 0, 0, 512, 512, 1), 1,
			hv(-512, 0, sbfh_pkg::SIDE_LEFT, 0));
		add_row(mk(2000, 0, 0, 0, 0, 0, 512, 512, 1), 1,
			hv(512, 0, sbfh_pkg::SIDE_RIGHT, 0));
		add_row(mk(-3000, 3000, 0, 0, 0, 0, 512, 512, 1), 0, z);
		add_row(mk(100, 3000, 101, 0, 0, 0, 512, 512, 1), 0, z);
		add_row(mk(100, -3000, 101, 0, 0, 0, 512, 512, 1), 0, z);
		add_row(mk(0, 3000, 0, 0, 0, 0, 512, 512, 1), 1, z);
		add_row(mk(0, 3000, 0, 3000, 0, 0, 512, 512, 1), 1, z);
		add_row(mk(-2000, 3000, 0, 3000, 0, 0, 512, 512, 1), 1, z);
		add_row(mk(mx, 0, mx, 0, mx, 0, mx, 10, 1), 1,
			hv(mx, 0, sbfh_pkg::SIDE_INSIDE, 0));
		add_row(mk(mn, 0, mx, 0, mx, 0, mx, 10, 1), 0, z);
		add_row(mk(mx, 0, mn, 0, mn, 0, mx, 10, 1), 0, z);
		add_row(mk(0, 0, 1, 1, mx, mx, mx, mx, 1), 0, z);
		add_row(mk(mn, mn, mx, mx, 0, 0, 0, 0, 1), 0, z);
		add_row(mk(mx, mx, mn, mn, 0, 0, mx, mx, 1), 0, z);
		add_row(mk(0, 0, 1, mx, 0, mx, 5, mx, 1), 0, z);
		add_row(mk(512, 0, 0, 0, 0, 0, 512, 512, 1), 0, z);
		add_row(mk(-1, -1, -1, -1, -1, -1, mx, mx, 1), 0, z);
	endtask

	task automatic send(shot_t s, bit known, hit_t h);
		int gap;
		hit_t p;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 120) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
		start <= 1;
		start_x <= s.sx; start_y <= s.sy; end_x <= s.ex; end_y <= s.ey;
		box_center_x <= s.cx; box_center_y <= s.cy;
		box_half_w <= s.hw; box_half_h <= s.hh; target_is_box <= s.isbox;
		do @(posedge clk); while (busy);
		p = known ? h : first_hit(s);
		pending_hits.insert(pending_hits.size(), p);
	endtask

	// Stimulus
	initial begin
		int wait_cyc;
		start = 0; arst_n = 0;
		start_x = 0; start_y = 0; end_x = 0; end_y = 0;
		box_center_x = 0; box_center_y = 0; box_half_w = 0; box_half_h = 0;
		target_is_box = 0;
		build_table();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].known && rows[i].h != first_hit(rows[i].s))
				$display("%t table row %0d disagrees with predictor", $time, i);
			send(rows[i].s, rows[i].known, rows[i].h);
		end
		for (int i = 0; i < N_RANDOM; i++)
			send(rand_shot(), 0, hv(0, 0, sbfh_pkg::SIDE_NONE, 0));
		start <= 0;
		wait_cyc = 0;
		while (pending_hits.size() != 0 && wait_cyc < 100 * LATENCY) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (LATENCY) @(posedge clk);
		if (pending_hits.size() != 0) begin
			$display("%t %0d expected hits never arrived", $time, pending_hits.size());
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		hit_t e;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$display("%t unexpected result beat x=%0d y=%0d side=%0d", $time,
					hit_x, hit_y, hit_side);
				errors++;
			end else begin
				e = pending_hits.pop_front();
				if (hit_x !== e.hx) begin
					$display("%t hit_x expected %0d actual %0d", $time, e.hx, hit_x);
					errors++;
				end
				if (hit_y !== e.hy) begin
					$display("%t hit_y expected %0d actual %0d", $time, e.hy, hit_y);
					errors++;
				end
				if (hit_side !== e.side) begin
					$display("%t hit_side expected %0d actual %0d", $time, e.side, hit_side);
					errors++;
				end
				if (clipped !== e.clip) begin
					$display("%t clipped expected %0d actual %0d", $time, e.clip, clipped);
					errors++;
				end
			end
		end
	end
endmodule

@@ sim.f @@
sv/sbfh_pkg.sv
sv/sbfh_div_pipe.sv
sv/segment_box_first_hit_top.sv
tb/segment_box_first_hit_top_test.sv
